// ----- sv/duplicate_packet_filter_core_assert.svh -----
// Assertion macros for the duplicate packet filter.
// Used by the checker; expects clk and rst in the scope where it is expanded.
`ifndef DUPLICATE_PACKET_FILTER_CORE_ASSERT_SVH
`define DUPLICATE_PACKET_FILTER_CORE_ASSERT_SVH

// Next-cycle check, ignored while reset is high.
`define DPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpf assertion failed");

// Next-cycle check that also holds across reset.
`define DPF_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpf assertion failed");

`endif

// ----- sv/dpf_pkg.sv -----
// Shared constants for the duplicate packet filter.
// No dependencies; used by the channel interfaces and the core.
package dpf_pkg;

  localparam int SRC_W = 6;
  localparam int SEQ_W = 32;

endpackage

// ----- sv/dpf_if.sv -----
// Valid/ready channels of the duplicate packet filter: packet beats in, verdict beats out.
// Depends on dpf_pkg for field widths.
interface dpf_in_if;
  logic                       valid;
  logic                       ready;
  logic [dpf_pkg::SRC_W-1:0]  source_address;
  logic [dpf_pkg::SEQ_W-1:0]  sequence_number;

  modport source (output valid, output source_address, output sequence_number, input ready);
  modport sink   (input valid, input source_address, input sequence_number, output ready);
endinterface

interface dpf_out_if;
  logic valid;
  logic ready;
  logic is_new;

  modport source (output valid, output is_new, input ready);
  modport sink   (input valid, input is_new, output ready);
endinterface

// ----- sv/duplicate_packet_filter_core.sv -----
// Per-source duplicate filter: a beat from a source out of range goes from idle to the done
// state; otherwise the history is scanned until a match (duplicate) or the fill count (new).
// The scan reads one history entry at a time through the history memory's read port,
// so an item occupies the block until its scan ends; one item at a time.
// Synchronous reset starts a clearing pass that zeroes each entry of the per-source
// fill/slot memory in turn; no packet beat is taken until it ends.
module duplicate_packet_filter_core #(
  parameter int NUM_SOURCES   = 64,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  dpf_in_if.sink    pkt,
  dpf_out_if.source res
);

  localparam int SW      = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int PW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW      = $clog2(HISTORY_DEPTH + 1);
  localparam int ENTRIES = NUM_SOURCES * HISTORY_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam logic [SW-1:0] LAST_SRC  = SW'(NUM_SOURCES - 1);
  localparam logic [FW-1:0] FULL      = FW'(HISTORY_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(HISTORY_DEPTH - 1);

  typedef struct packed {
    logic [FW-1:0] fill;
    logic [PW-1:0] newest;
  } meta_t;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_META = 8'b0000_0100,
    S_LOAD = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  logic [dpf_pkg::SEQ_W-1:0] store_mem [ENTRIES];
  meta_t                     meta_mem  [NUM_SOURCES];

  state_t                    state;
  logic [SW-1:0]             clr_idx;
  logic [SW-1:0]             src_idx;
  logic [dpf_pkg::SEQ_W-1:0] seq;
  logic [FW-1:0]             fill;
  logic [PW-1:0]             newest;
  logic [AW-1:0]             base;
  logic [FW-1:0]             idx;
  logic                      new_r;
  logic [dpf_pkg::SEQ_W-1:0] store_q;
  meta_t                     meta_q;
  logic                      out_valid;
  logic                      out_is_new;

  logic                      accept;
  logic                      src_ok;
  logic [PW-1:0]             slot;
  logic [FW-1:0]             fill_next;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic                      meta_we;
  logic [SW-1:0]             meta_waddr;
  meta_t                     meta_wdata;

  assign pkt.ready  = (state == S_IDLE) && (!out_valid || res.ready);
  assign accept     = pkt.valid && pkt.ready;
  assign src_ok     = 32'(pkt.source_address) < NUM_SOURCES;
  assign res.valid  = out_valid;
  assign res.is_new = out_is_new;

  always_comb begin
    if (fill == '0) begin
      slot = '0;
    end else if (newest == LAST_SLOT) begin
      slot = '0;
    end else begin
      slot = PW'(newest + 1'b1);
    end
    fill_next  = (fill == FULL) ? fill : FW'(fill + 1'b1);
    rd_addr    = AW'(base + AW'(idx));
    wr_addr    = AW'(base + AW'(slot));
    meta_we    = (state == S_CLR) || (state == S_WR);
    meta_waddr = (state == S_CLR) ? clr_idx : src_idx;
    if (state == S_CLR) begin
      meta_wdata = '0;
    end else begin
      meta_wdata.fill   = fill_next;
      meta_wdata.newest = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_q <= meta_mem[src_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      store_mem[wr_addr] <= seq;
    end
    store_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_idx <= SW'(clr_idx + 1'b1);
          if (clr_idx == LAST_SRC) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= src_ok ? S_META : S_DONE;
          end
        end
        S_META: state <= S_LOAD;
        S_LOAD: state <= S_RD;
        S_RD:   state <= (idx == fill) ? S_WR : S_CMP;
        S_CMP:  state <= (store_q == seq) ? S_DONE : S_RD;
        S_WR:   state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          src_idx <= SW'(pkt.source_address);
          seq     <= pkt.sequence_number;
          new_r   <= 1'b1;
        end
      end
      S_LOAD: begin
        fill   <= meta_q.fill;
        newest <= meta_q.newest;
        base   <= AW'(AW'(src_idx) * AW'(HISTORY_DEPTH));
        idx    <= '0;
      end
      S_CMP: begin
        if (store_q == seq) begin
          new_r <= 1'b0;
        end
        idx <= FW'(idx + 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      out_is_new <= new_r;
    end
  end

endmodule

// ----- sv/dpf_checker.sv -----
// Port-level checks for the duplicate packet filter, bound to the core.
// Depends on duplicate_packet_filter_core_assert.svh and the core's channel ports.
`include "duplicate_packet_filter_core_assert.svh"

module dpf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_new
);

  `DPF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `DPF_ASSERT_NEXT(a_verdict_held, out_valid && !out_ready, out_valid && $stable(out_is_new))
  `DPF_ASSERT_NEXT(a_single_verdict, out_valid && out_ready, !out_valid)
  `DPF_ASSERT_NEXT_RST(a_reset_quiet, rst, !in_ready && !out_valid)

endmodule

bind duplicate_packet_filter_core dpf_checker u_dpf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pkt.valid),
  .in_ready   (pkt.ready),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .out_is_new (res.is_new)
);
